[design/rcr_pkg.sv]
// Package for the radar coordinate rotation block: widths, CORDIC constants
// and the arctangent table. Used by every module in design/.
`default_nettype none

package rcr_pkg;

	localparam int COORD_WIDTH   = 16;
	localparam int CORDIC_STAGES = 16;

	// fraction bits added to coordinates inside the CORDIC
	localparam int GUARD_BITS = 16;
	// extra integer bits for CORDIC gain and vector growth
	localparam int GROW_BITS  = 3;

	localparam int TILT_WIDTH  = 15;
	localparam int ANGLE_WIDTH = 24;   // accumulator, units of 2^-20 rad
	localparam int ANGLE_SHIFT = 7;    // Q2.13 -> 2^-20
	localparam int ANGLE_MAX   = 12868;

	// round(0.6072529350 * 2^16), 17 bits signed
	localparam int GAIN_WIDTH = 17;
	localparam logic signed [GAIN_WIDTH-1:0] GAIN_Q16 = 17'sd39797;

	typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

	// round(atan(2^-i) * 2^20)
	function automatic angle_t atan_lut(input logic [4:0] idx);
		angle_t v;
		case (idx)
			5'd0:    v = 24'sd823550;
			5'd1:    v = 24'sd486170;
			5'd2:    v = 24'sd256879;
			5'd3:    v = 24'sd130396;
			5'd4:    v = 24'sd65451;
			5'd5:    v = 24'sd32757;
			5'd6:    v = 24'sd16383;
			5'd7:    v = 24'sd8192;
			5'd8:    v = 24'sd4096;
			5'd9:    v = 24'sd2048;
			5'd10:   v = 24'sd1024;
			5'd11:   v = 24'sd512;
			5'd12:   v = 24'sd256;
			5'd13:   v = 24'sd128;
			5'd14:   v = 24'sd64;
			5'd15:   v = 24'sd32;
			5'd16:   v = 24'sd16;
			5'd17:   v = 24'sd8;
			5'd18:   v = 24'sd4;
			5'd19:   v = 24'sd2;
			5'd20:   v = 24'sd1;
			5'd21:   v = 24'sd1;
			default: v = 24'sd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[design/radar_coordinate_rotation.sv]
// Radar coordinate rotation: position and velocity lanes rotated by minus the tilt.
// Pipeline stages from start to result_valid:
// one input stage, one stage per micro-rotation, the gain multiply, the output register.
// Throughput one detection per cycle; busy stays low, results cannot be stalled.
// Reset clears tilt_q to 0 and empties the valid pipeline.
// Depends on rcr_pkg, rcr_angle_path and rcr_lane.
`default_nettype none

module radar_coordinate_rotation #(
	parameter int COORD_WIDTH   = rcr_pkg::COORD_WIDTH,
	parameter int CORDIC_STAGES = rcr_pkg::CORDIC_STAGES
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic signed [rcr_pkg::TILT_WIDTH-1:0] cfg_wr_data,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [COORD_WIDTH-1:0]         pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]         pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]         vel_x,
	input  wire logic signed [COORD_WIDTH-1:0]         vel_y,
	output logic                                       result_valid,
	output logic signed      [COORD_WIDTH-1:0]         rot_pos_x,
	output logic signed      [COORD_WIDTH-1:0]         rot_pos_y,
	output logic signed      [COORD_WIDTH-1:0]         rot_vel_x,
	output logic signed      [COORD_WIDTH-1:0]         rot_vel_y,
	output logic                                       saturated
);

	localparam int VLD_LEN = CORDIC_STAGES + 2;

	logic signed [rcr_pkg::TILT_WIDTH-1:0] tilt_q;
	logic        [VLD_LEN-1:0]             vld_q;
	logic        [CORDIC_STAGES-1:0]       dir;
	logic signed [COORD_WIDTH-1:0]         lp_x;
	logic signed [COORD_WIDTH-1:0]         lp_y;
	logic signed [COORD_WIDTH-1:0]         lv_x;
	logic signed [COORD_WIDTH-1:0]         lv_y;
	logic                                  p_sat;
	logic                                  v_sat;
	logic                                  valid_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q <= '0;
		end else if (cfg_wr_en) begin
			tilt_q <= cfg_wr_data;
		end
	end

	// transfer tracking alongside the data pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			vld_q   <= {vld_q[VLD_LEN-2:0], start & ~busy};
			valid_q <= vld_q[VLD_LEN-1];
		end
	end

	rcr_angle_path #(
		.STAGES (CORDIC_STAGES)
	) u_angle (
		.clk  (clk),
		.tilt (tilt_q),
		.dir  (dir)
	);

	rcr_lane #(
		.COORD_W (COORD_WIDTH),
		.STAGES  (CORDIC_STAGES)
	) u_pos_lane (
		.clk   (clk),
		.in_x  (pos_x),
		.in_y  (pos_y),
		.dir   (dir),
		.out_x (lp_x),
		.out_y (lp_y),
		.sat   (p_sat)
	);

	rcr_lane #(
		.COORD_W (COORD_WIDTH),
		.STAGES  (CORDIC_STAGES)
	) u_vel_lane (
		.clk   (clk),
		.in_x  (vel_x),
		.in_y  (vel_y),
		.dir   (dir),
		.out_x (lv_x),
		.out_y (lv_y),
		.sat   (v_sat)
	);

	// merge stage: collect both lanes and the combined clip flag
	always_ff @(posedge clk) begin
		rot_pos_x <= lp_x;
		rot_pos_y <= lp_y;
		rot_vel_x <= lv_x;
		rot_vel_y <= lv_y;
		saturated <= p_sat | v_sat;
	end

	assign result_valid = valid_q;

endmodule

`default_nettype wire

[design/rcr_angle_path.sv]
// Angle accumulator pipeline: clamps the tilt, negates it and produces the
// per-stage rotation directions shared by all lanes. Depends on rcr_pkg.
`default_nettype none

module rcr_angle_path #(
	parameter int STAGES = rcr_pkg::CORDIC_STAGES
) (
	input  wire logic                                  clk,
	input  wire logic signed [rcr_pkg::TILT_WIDTH-1:0] tilt,
	output logic             [STAGES-1:0]              dir
);

	localparam int ZW = rcr_pkg::ANGLE_WIDTH;

	localparam logic signed [rcr_pkg::TILT_WIDTH-1:0] TiltHi =
		rcr_pkg::TILT_WIDTH'(rcr_pkg::ANGLE_MAX);
	localparam logic signed [rcr_pkg::TILT_WIDTH-1:0] TiltLo =
		rcr_pkg::TILT_WIDTH'(-rcr_pkg::ANGLE_MAX);

	logic signed [rcr_pkg::TILT_WIDTH-1:0] tilt_c;
	rcr_pkg::angle_t                       z_init;
	rcr_pkg::angle_t                       z_s [0:STAGES-1];

	always_comb begin
		if (tilt > TiltHi) begin
			tilt_c = TiltHi;
		end else if (tilt < TiltLo) begin
			tilt_c = TiltLo;
		end else begin
			tilt_c = tilt;
		end
		z_init = -(ZW'(tilt_c) <<< rcr_pkg::ANGLE_SHIFT);
	end

	always_ff @(posedge clk) begin
		z_s[0] <= z_init;
	end

	genvar i;
	generate
		for (i = 0; i < STAGES; i++) begin : g_dir
			// zero counts as non-negative: counterclockwise
			assign dir[i] = ~z_s[i][ZW-1];
		end
		for (i = 0; i < STAGES - 1; i++) begin : g_stage
			always_ff @(posedge clk) begin
				if (dir[i]) begin
					z_s[i+1] <= z_s[i] - rcr_pkg::atan_lut(5'(i));
				end else begin
					z_s[i+1] <= z_s[i] + rcr_pkg::atan_lut(5'(i));
				end
			end
		end
	endgenerate

endmodule

`default_nettype wire

[design/rcr_lane.sv]
// One CORDIC rotation lane for an (x, y) vector: input scaling, micro-rotation
// stages steered by shared directions, gain multiply, rounding and clipping.
// Depends on rcr_pkg.
`default_nettype none

module rcr_lane #(
	parameter int COORD_W = rcr_pkg::COORD_WIDTH,
	parameter int STAGES  = rcr_pkg::CORDIC_STAGES
) (
	input  wire logic                      clk,
	input  wire logic signed [COORD_W-1:0] in_x,
	input  wire logic signed [COORD_W-1:0] in_y,
	input  wire logic        [STAGES-1:0]  dir,
	output logic signed      [COORD_W-1:0] out_x,
	output logic signed      [COORD_W-1:0] out_y,
	output logic                           sat
);

	localparam int W  = COORD_W + rcr_pkg::GUARD_BITS + rcr_pkg::GROW_BITS;
	localparam int PW = W + rcr_pkg::GAIN_WIDTH;
	localparam int RW = PW - 32;

	localparam logic signed [PW-1:0] RoundHalf = {{(PW-32){1'b0}}, 1'b1, 31'b0};
	localparam logic signed [RW-1:0] SatHi =
		{{(RW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [RW-1:0] SatLo = ~SatHi;

	logic signed [W-1:0]  x_s [0:STAGES];
	logic signed [W-1:0]  y_s [0:STAGES];
	logic signed [PW-1:0] px_s1;
	logic signed [PW-1:0] py_s1;
	logic signed [PW-1:0] sum_x;
	logic signed [PW-1:0] sum_y;
	logic signed [RW-1:0] rx;
	logic signed [RW-1:0] ry;
	logic                 sat_x;
	logic                 sat_y;

	always_ff @(posedge clk) begin
		x_s[0] <= W'(in_x) <<< rcr_pkg::GUARD_BITS;
		y_s[0] <= W'(in_y) <<< rcr_pkg::GUARD_BITS;
	end

	genvar i;
	generate
		for (i = 0; i < STAGES; i++) begin : g_stage
			always_ff @(posedge clk) begin
				if (dir[i]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		px_s1 <= PW'(x_s[STAGES]) * PW'(rcr_pkg::GAIN_Q16);
		py_s1 <= PW'(y_s[STAGES]) * PW'(rcr_pkg::GAIN_Q16);
	end

	// round half up, drop 32 fraction bits, clip to COORD_W
	always_comb begin
		sum_x = px_s1 + RoundHalf;
		sum_y = py_s1 + RoundHalf;
		rx    = sum_x[PW-1:32];
		ry    = sum_y[PW-1:32];
		sat_x = 1'b0;
		sat_y = 1'b0;
		if (rx > SatHi) begin
			out_x = SatHi[COORD_W-1:0];
			sat_x = 1'b1;
		end else if (rx < SatLo) begin
			out_x = SatLo[COORD_W-1:0];
			sat_x = 1'b1;
		end else begin
			out_x = rx[COORD_W-1:0];
		end
		if (ry > SatHi) begin
			out_y = SatHi[COORD_W-1:0];
			sat_y = 1'b1;
		end else if (ry < SatLo) begin
			out_y = SatLo[COORD_W-1:0];
			sat_y = 1'b1;
		end else begin
			out_y = ry[COORD_W-1:0];
		end
		sat = sat_x | sat_y;
	end

endmodule

`default_nettype wire
